[sv/upload_stream_crc_verifier_unit_defines.svh]
`ifndef UPLOAD_STREAM_CRC_VERIFIER_UNIT_DEFINES_SVH
`define UPLOAD_STREAM_CRC_VERIFIER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define USCV_ASSERT_NOW(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("uscv assertion failed");

// Next-cycle implication, disabled during reset.
`define USCV_ASSERT_NEXT(label, clk, rst, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("uscv assertion failed");

`endif

[sv/uscv_pkg.sv]
package uscv_pkg;

  localparam int unsigned PAGE_BYTES_DEFAULT = 256;

  localparam logic [31:0] CRC_POLY      = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT      = 32'hFFFF_FFFF;
  localparam logic [31:0] TOTAL_RESET   = 32'd1;
  localparam logic [31:0] EXPECT_RESET  = 32'd0;
  localparam logic [31:0] TIMEOUT_RESET = 32'd15000000;

  typedef enum logic [1:0] {
    OP_ARM   = 2'd0,
    OP_DATA  = 2'd1,
    OP_ABORT = 2'd2,
    OP_TICK  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    REG_BYTE_TARGET   = 2'd0,
    REG_CRC_TARGET    = 2'd1,
    REG_TIMEOUT_TICKS = 2'd2
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_TAKEN     = 3'd0,
    ST_OK        = 3'd1,
    ST_MISMATCH  = 3'd2,
    ST_TIMEOUT   = 3'd3,
    ST_ABORTED   = 3'd4,
    ST_READY     = 3'd5,
    ST_BUSY      = 3'd6,
    ST_NOSESSION = 3'd7
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  out_byte;
    logic [7:0]  page_offset;
    logic        page_end;
    logic [31:0] final_crc;
    logic [31:0] received_count;
  } result_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
    logic [31:0] c;
    c = crc_in ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (c[0] ? CRC_POLY : 32'b0);
    end
    return c;
  endfunction

endpackage

[sv/upload_stream_crc_verifier_unit.sv]
// Upload session receiver with a reflected CRC-32 check (polynomial 0xEDB88320).
// Requests carry an opcode (arm, data byte, abort, tick); a new one is accepted
// every cycle while the two-entry result buffer has room. The per-request path
// is the eight-step CRC XOR network on the byte plus the 32-bit count compare
// against the byte target, both between the session registers and the result
// buffer. in_ready drops only when a result waits in both buffer entries.
// Ticks with no session, and ticks short of the timeout, produce no result.
// Configuration writes are taken every cycle and should be made while the
// block is idle. page_offset carries the low 8 bits of the page position.
`include "upload_stream_crc_verifier_unit_defines.svh"

module upload_stream_crc_verifier_unit #(
  parameter int unsigned PAGE_BYTES = uscv_pkg::PAGE_BYTES_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  opcode,
  input  logic [7:0]  data_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [7:0]  out_byte,
  output logic [7:0]  page_offset,
  output logic        page_end,
  output logic [31:0] final_crc,
  output logic [31:0] received_count,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int unsigned PW = $clog2(PAGE_BYTES);

  logic [31:0] byte_target;
  logic [31:0] crc_target;
  logic [31:0] timeout_ticks;

  logic          active, active_next;
  logic [31:0]   crc, crc_next;
  logic [31:0]   count, count_next;
  logic [PW-1:0] pos, pos_next;
  logic [31:0]   idle, idle_next;

  logic              in_accept;
  logic              has_res;
  uscv_pkg::result_t res;
  uscv_pkg::result_t out_data;

  logic [PW+7:0] pos_ext;
  logic [31:0]   crc_upd;
  logic [31:0]   cnt_inc;
  logic [31:0]   idle_sat;
  logic [31:0]   fin;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && in_ready;
  assign pos_ext   = {8'b0, pos};
  assign crc_upd   = uscv_pkg::crc_byte(crc, data_byte);
  assign cnt_inc   = count + 32'd1;
  assign idle_sat  = (idle == 32'hFFFF_FFFF) ? idle : idle + 32'd1;
  assign fin       = ~crc_upd;

  always_comb begin
    active_next = active;
    crc_next    = crc;
    count_next  = count;
    pos_next    = pos;
    idle_next   = idle;
    has_res     = 1'b1;
    res         = '0;
    res.status  = uscv_pkg::ST_NOSESSION;
    case (uscv_pkg::opcode_t'(opcode))
      uscv_pkg::OP_ARM: begin
        if (active) begin
          res.status = uscv_pkg::ST_BUSY;
        end else begin
          active_next = 1'b1;
          crc_next    = uscv_pkg::CRC_INIT;
          count_next  = '0;
          pos_next    = '0;
          idle_next   = '0;
          res.status  = uscv_pkg::ST_READY;
        end
      end
      uscv_pkg::OP_DATA: begin
        if (active) begin
          idle_next          = '0;
          res.out_byte       = data_byte;
          res.page_offset    = pos_ext[7:0];
          res.received_count = cnt_inc;
          if (pos == PW'(PAGE_BYTES - 1)) begin
            pos_next     = '0;
            res.page_end = 1'b1;
          end else begin
            pos_next = pos + PW'(1);
          end
          if (cnt_inc >= byte_target) begin
            res.page_end  = 1'b1;
            res.final_crc = fin;
            res.status    = (fin == crc_target) ? uscv_pkg::ST_OK : uscv_pkg::ST_MISMATCH;
            active_next   = 1'b0;
            crc_next      = uscv_pkg::CRC_INIT;
            count_next    = '0;
            pos_next      = '0;
            idle_next     = '0;
          end else begin
            crc_next   = crc_upd;
            count_next = cnt_inc;
            res.status = uscv_pkg::ST_TAKEN;
          end
        end
      end
      uscv_pkg::OP_ABORT: begin
        if (active) begin
          res.status         = uscv_pkg::ST_ABORTED;
          res.received_count = count;
          active_next        = 1'b0;
          crc_next           = uscv_pkg::CRC_INIT;
          count_next         = '0;
          pos_next           = '0;
          idle_next          = '0;
        end
      end
      uscv_pkg::OP_TICK: begin
        has_res = 1'b0;
        if (active) begin
          if (idle_sat >= timeout_ticks) begin
            has_res            = 1'b1;
            res.status         = uscv_pkg::ST_TIMEOUT;
            res.received_count = count;
            active_next        = 1'b0;
            crc_next           = uscv_pkg::CRC_INIT;
            count_next         = '0;
            pos_next           = '0;
            idle_next          = '0;
          end else begin
            idle_next = idle_sat;
          end
        end
      end
      default: begin
        has_res = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_target   <= uscv_pkg::TOTAL_RESET;
      crc_target    <= uscv_pkg::EXPECT_RESET;
      timeout_ticks <= uscv_pkg::TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (uscv_pkg::reg_index_t'(cfg_index))
        uscv_pkg::REG_BYTE_TARGET:   byte_target   <= cfg_data;
        uscv_pkg::REG_CRC_TARGET:    crc_target    <= cfg_data;
        uscv_pkg::REG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      crc    <= uscv_pkg::CRC_INIT;
      count  <= '0;
      pos    <= '0;
      idle   <= '0;
    end else if (in_accept) begin
      active <= active_next;
      crc    <= crc_next;
      count  <= count_next;
      pos    <= pos_next;
      idle   <= idle_next;
    end
  end

  uscv_out_buf u_out_buf (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid && has_res),
    .push_ready (in_ready),
    .push_data  (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

  assign status         = out_data.status;
  assign out_byte       = out_data.out_byte;
  assign page_offset    = out_data.page_offset;
  assign page_end       = out_data.page_end;
  assign final_crc      = out_data.final_crc;
  assign received_count = out_data.received_count;

  `USCV_ASSERT_NOW(a_idle_is_clear, clk, rst, !active,
    count == 32'd0 && crc == uscv_pkg::CRC_INIT && idle == 32'd0)
  `USCV_ASSERT_NEXT(a_close_ends_session, clk, rst,
    in_accept && has_res && (res.status == uscv_pkg::ST_OK ||
    res.status == uscv_pkg::ST_MISMATCH || res.status == uscv_pkg::ST_TIMEOUT ||
    res.status == uscv_pkg::ST_ABORTED), !active)
  `USCV_ASSERT_NOW(a_ok_matches, clk, rst,
    in_accept && has_res && res.status == uscv_pkg::ST_OK, res.final_crc == crc_target)

endmodule

[sv/uscv_out_buf.sv]
`include "upload_stream_crc_verifier_unit_defines.svh"

module uscv_out_buf (
  input  logic              clk,
  input  logic              rst,
  input  logic              push_valid,
  output logic              push_ready,
  input  uscv_pkg::result_t push_data,
  output logic              out_valid,
  input  logic              out_ready,
  output uscv_pkg::result_t out_data
);

  logic              main_valid;
  logic              skid_valid;
  uscv_pkg::result_t main;
  uscv_pkg::result_t skid;
  logic              push;

  assign push_ready = !skid_valid;
  assign push       = push_valid && push_ready;
  assign out_valid  = main_valid;
  assign out_data   = main;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!main_valid || out_ready) begin
      if (skid_valid) begin
        main       <= skid;
        main_valid <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        main       <= push_data;
        main_valid <= push;
      end
    end else if (push) begin
      skid       <= push_data;
      skid_valid <= 1'b1;
    end
  end

  `USCV_ASSERT_NOW(a_skid_needs_main, clk, rst, skid_valid, main_valid)
  `USCV_ASSERT_NEXT(a_stall_fills_skid, clk, rst, push && main_valid && !out_ready, skid_valid)
  `USCV_ASSERT_NEXT(a_empty_no_skid, clk, rst, !main_valid, !skid_valid)

endmodule

[tb/sv/tb_upload_stream_crc_verifier_unit.sv]
module tb_upload_stream_crc_verifier_unit;
  import uscv_pkg::*;

  localparam int unsigned PAGE = PAGE_BYTES_DEFAULT;
  localparam int SETTLE = 8;
  localparam int LONG_HOLD = 300;

  typedef struct {
    opcode_t    op;
    logic [7:0] b;
  } request_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  opcode = OP_TICK;
  logic [7:0]  data_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [7:0]  out_byte;
  logic [7:0]  page_offset;
  logic        page_end;
  logic [31:0] final_crc;
  logic [31:0] received_count;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_BYTE_TARGET;
  logic [31:0] cfg_data = 32'h0;

  request_t upload_requests[$];
  result_t  expected_replies[$];

  logic [31:0] cfg_total = TOTAL_RESET;
  logic [31:0] cfg_expect = EXPECT_RESET;
  logic [31:0] cfg_timeout = TIMEOUT_RESET;
  bit          sess_open = 1'b0;
  logic [31:0] crc_reg = CRC_INIT;
  logic [31:0] bytes_seen = 32'h0;
  int unsigned page_pos = 0;
  logic [31:0] idle_count = 32'h0;

  logic [7:0] session_bytes[$];
  int         tick_limit = 1;
  int         stimulus_count = 0;
  int         failures = 0;
  bit         quiet = 1'b0;
  bit         hold_due = 1'b0;
  bit         hold_done = 1'b0;
  int         hold_left = 0;
  int         gap_left = 0;
  int         stall_left = 0;

  upload_stream_crc_verifier_unit dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .opcode(opcode),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status(status),
    .out_byte(out_byte),
    .page_offset(page_offset),
    .page_end(page_end),
    .final_crc(final_crc),
    .received_count(received_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [31:0] crc32_reflect_byte(logic [31:0] acc, logic [7:0] b);
    logic [31:0] c;
    logic lsb;
    c = acc ^ {24'h0, b};
    repeat (8) begin
      lsb = c[0];
      c = {1'b0, c[31:1]};
      if (lsb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic clear_session();
    sess_open = 1'b0;
    crc_reg = CRC_INIT;
    bytes_seen = 32'h0;
    page_pos = 0;
    idle_count = 32'h0;
  endtask

  task automatic predict_upload(opcode_t op, logic [7:0] b);
    result_t r;
    logic [31:0] fin;
    r = '0;
    case (op)
      OP_ARM: begin
        if (sess_open) begin
          r.status = ST_BUSY;
        end else begin
          clear_session();
          sess_open = 1'b1;
          r.status = ST_READY;
        end
        expected_replies.push_back(r);
      end
      OP_DATA: begin
        if (!sess_open) begin
          r.status = ST_NOSESSION;
        end else begin
          idle_count = 32'h0;
          r.out_byte = b;
          r.page_offset = page_pos[7:0];
          crc_reg = crc32_reflect_byte(crc_reg, b);
          bytes_seen = bytes_seen + 32'd1;
          page_pos++;
          if (page_pos >= PAGE) begin
            page_pos = 0;
            r.page_end = 1'b1;
          end
          r.received_count = bytes_seen;
          if (bytes_seen >= cfg_total) begin
            fin = ~crc_reg;
            r.page_end = 1'b1;
            r.final_crc = fin;
            r.status = (fin == cfg_expect) ? ST_OK : ST_MISMATCH;
            clear_session();
          end else begin
            r.status = ST_TAKEN;
          end
        end
        expected_replies.push_back(r);
      end
      OP_ABORT: begin
        if (!sess_open) begin
          r.status = ST_NOSESSION;
        end else begin
          r.status = ST_ABORTED;
          r.received_count = bytes_seen;
          clear_session();
        end
        expected_replies.push_back(r);
      end
      default: begin
        if (sess_open) begin
          if (idle_count != 32'hFFFF_FFFF) idle_count = idle_count + 32'd1;
          if (idle_count >= cfg_timeout) begin
            r.status = ST_TIMEOUT;
            r.received_count = bytes_seen;
            clear_session();
            expected_replies.push_back(r);
          end
        end
      end
    endcase
  endtask

  task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
      failures++;
    end
  endtask

  task automatic push_req(opcode_t op, logic [7:0] b, bit counted = 1'b1);
    request_t q;
    q.op = op;
    q.b = b;
    upload_requests.push_back(q);
    if (counted) stimulus_count++;
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_BYTE_TARGET:   cfg_total = val;
      REG_CRC_TARGET:    cfg_expect = val;
      REG_TIMEOUT_TICKS: cfg_timeout = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (upload_requests.size() != 0 || in_valid || expected_replies.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  // one session built from session_bytes, or noise
  task automatic queue_session(bit clean_only);
    int v;
    int cut;
    int k;
    logic [7:0] mask;
    v = clean_only ? 0 : $urandom_range(0, 9);
    cut = $urandom_range(0, session_bytes.size() - 1);
    mask = 8'($urandom_range(1, 255));
    if (!clean_only && $urandom_range(0, 3) == 0) begin
      push_req(OP_TICK, 8'($urandom()), 1'b0);
      push_req(opcode_t'($urandom_range(1, 2)), 8'($urandom()));
    end
    if (v == 8) begin
      repeat ($urandom_range(3, 8)) push_req(opcode_t'($urandom_range(0, 3)), 8'($urandom()));
    end else begin
      push_req(OP_ARM, 8'($urandom()));
      for (k = 0; k < session_bytes.size(); k++) begin
        if (k == cut && v >= 6) break;
        if (tick_limit > 1 && $urandom_range(0, 5) == 0)
          repeat ($urandom_range(1, tick_limit - 1)) push_req(OP_TICK, 8'($urandom()));
        if (k == cut && v == 4) push_req(OP_ARM, 8'($urandom()));
        push_req(OP_DATA, (k == cut && v == 5) ? session_bytes[k] ^ mask : session_bytes[k]);
      end
      case (v)
        6: push_req(OP_ABORT, 8'($urandom()));
        7: repeat (tick_limit) push_req(OP_TICK, 8'($urandom()));
        9: begin
          push_req(OP_ARM, 8'($urandom()));
          push_req(OP_ABORT, 8'($urandom()));
        end
        default: ;
      endcase
    end
  endtask

  always @(posedge clk) begin : request_driver
    logic nv;
    request_t q;
    if (rst) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      nv = in_valid;
      if (in_valid && in_ready) begin
        predict_upload(opcode_t'(opcode), data_byte);
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
          gap_left = $urandom_range(0, 7);
        end else if (upload_requests.size() > 0) begin
          q = upload_requests.pop_front();
          opcode <= q.op;
          data_byte <= q.b;
          nv = 1'b1;
        end
      end
      in_valid <= nv;
    end
  end

  always @(posedge clk) begin : reply_monitor
    logic nr;
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_replies.size() == 0) begin
          $display("%0t: unexpected reply, expected none, got status %0d", $time, status);
          failures++;
        end else begin
          want = expected_replies.pop_front();
          compare_field("status", 32'(want.status), 32'(status));
          compare_field("out_byte", 32'(want.out_byte), 32'(out_byte));
          compare_field("page_offset", 32'(want.page_offset), 32'(page_offset));
          compare_field("page_end", 32'(want.page_end), 32'(page_end));
          compare_field("final_crc", want.final_crc, final_crc);
          compare_field("received_count", want.received_count, received_count);
        end
      end
      if (hold_due && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        nr = 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        nr = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 7);
        nr = 1'b0;
      end else begin
        nr = 1'b1;
      end
      out_ready <= nr;
    end
  end

  initial begin
    #2_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    int phase;
    int n;
    logic [31:0] c;
    rst = 1'b1;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    push_req(OP_TICK, 8'h00);
    push_req(OP_DATA, 8'hFF);
    push_req(OP_ABORT, 8'h00);
    push_req(OP_ARM, 8'h00);
    push_req(OP_ARM, 8'hFF);
    push_req(OP_TICK, 8'h00);
    push_req(OP_DATA, 8'h00);
    push_req(OP_ARM, 8'h00);
    push_req(OP_ABORT, 8'h00);
    wait_quiet();

    // zero count and zero timeout close on the first byte or tick
    write_reg(REG_CRC_TARGET, ~crc32_reflect_byte(CRC_INIT, 8'hFF));
    write_reg(REG_BYTE_TARGET, 32'h0);
    write_reg(REG_TIMEOUT_TICKS, 32'h0);
    push_req(OP_ARM, 8'h00);
    push_req(OP_TICK, 8'h00);
    push_req(OP_ARM, 8'h00);
    push_req(OP_DATA, 8'hFF);
    wait_quiet();

    write_reg(REG_BYTE_TARGET, 32'hFFFF_FFFF);
    write_reg(REG_CRC_TARGET, 32'hFFFF_FFFF);
    write_reg(REG_TIMEOUT_TICKS, 32'hFFFF_FFFF);
    push_req(OP_ARM, 8'h00);
    push_req(OP_DATA, 8'h80);
    push_req(OP_DATA, 8'h01);
    push_req(OP_TICK, 8'h00);
    push_req(OP_DATA, 8'h7F);
    push_req(OP_ABORT, 8'h00);
    wait_quiet();

    write_reg(REG_BYTE_TARGET, 32'd1);
    write_reg(REG_TIMEOUT_TICKS, 32'd1);
    push_req(OP_ARM, 8'h00);
    push_req(OP_TICK, 8'h00);
    wait_quiet();

    write_reg(REG_BYTE_TARGET, 32'd2);
    write_reg(REG_CRC_TARGET, 32'h0);
    push_req(OP_ARM, 8'h00);
    push_req(OP_DATA, 8'h55);
    push_req(OP_DATA, 8'hAA);
    wait_quiet();

    stimulus_count = 0;
    phase = 0;
    while (stimulus_count < 650) begin
      if (phase == 3) n = $urandom_range(PAGE + 1, PAGE + 44);
      else if ($urandom_range(0, 3) == 0) n = $urandom_range(9, 40);
      else n = $urandom_range(1, 8);
      session_bytes.delete();
      c = CRC_INIT;
      repeat (n) begin
        session_bytes.push_back(8'($urandom()));
        c = crc32_reflect_byte(c, session_bytes[$]);
      end
      tick_limit = $urandom_range(1, 6);
      write_reg(REG_BYTE_TARGET, n);
      write_reg(REG_CRC_TARGET, ($urandom_range(0, 4) == 0) ? $urandom() : ~c);
      write_reg(REG_TIMEOUT_TICKS, tick_limit);
      if (phase == 3) begin
        queue_session(1'b1);
        @(negedge clk);
        hold_due = 1'b1;
      end else begin
        repeat ($urandom_range(2, 5)) queue_session(1'b0);
      end
      if (stimulus_count > 560) quiet = 1'b1;
      wait_quiet();
      phase++;
    end

    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+sv
sv/uscv_pkg.sv
sv/uscv_out_buf.sv
sv/upload_stream_crc_verifier_unit.sv
tb/sv/tb_upload_stream_crc_verifier_unit.sv
